// ===== rtl/core/bid_pkg.sv =====
// ----------------------------------------------------------------------------
// bid_pkg
// Shared types and constants for the bytecode instruction decoder.
// ----------------------------------------------------------------------------
package bid_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned HALF_W   = 16;
	localparam int unsigned ARG_W    = 32;
	localparam int unsigned CFG_W    = 8;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [BYTE_W-1:0] STOP_OPCODE       = 8'd0;
	localparam logic [CFG_W-1:0]  THRESHOLD_RESET   = 8'd90;
	localparam logic [CFG_W-1:0]  EXT_OPCODE_RESET  = 8'd145;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXT_OPCODE = 1'b1;

	typedef struct packed {
		logic [BYTE_W-1:0] code_byte;
		logic              end_of_code;
	} in_word_t;

	typedef struct packed {
		logic [BYTE_W-1:0]       opcode_out;
		logic signed [ARG_W-1:0] argument;
		logic                    has_argument;
		logic [HALF_W-1:0]       instr_offset;
		logic                    truncated;
	} out_word_t;

	typedef struct packed {
		logic [CFG_W-1:0] have_argument_threshold;
		logic [CFG_W-1:0] extended_opcode;
	} cfg_t;

	typedef enum logic [5:0] {
		PH_OPCODE = 6'b000001,
		PH_EXT_LO = 6'b000010,
		PH_EXT_HI = 6'b000100,
		PH_EXT_OP = 6'b001000,
		PH_ARG_LO = 6'b010000,
		PH_ARG_HI = 6'b100000
	} phase_t;

endpackage

// ===== rtl/core/bid_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bid_cfg_regs
// Configuration registers: argument threshold and extension prefix opcode.
// ----------------------------------------------------------------------------
module bid_cfg_regs import bid_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.have_argument_threshold <= THRESHOLD_RESET;
			cfg_q.extended_opcode         <= EXT_OPCODE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_THRESHOLD:  cfg_q.have_argument_threshold <= cfg_data;
				CFG_EXT_OPCODE: cfg_q.extended_opcode         <= cfg_data;
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/bid_parser.sv =====
// ----------------------------------------------------------------------------
// bid_parser
// Parse state machine and result register: one byte word per cycle unless a result waits on a stalled output.
// ----------------------------------------------------------------------------
module bid_parser import bid_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      valid_s1,
	input  in_word_t  word_s1,
	output logic      take,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word
);

	phase_t            phase_q, phase_n;
	logic [HALF_W-1:0] upper_q, upper_n;
	logic [BYTE_W-1:0] held_op_q, held_op_n;
	logic [BYTE_W-1:0] low_q, low_n;
	logic [HALF_W-1:0] offset_q, offset_n;
	logic [HALF_W-1:0] start_q, start_n;
	logic              emit;
	out_word_t         res;
	logic              out_valid_q;
	out_word_t         out_word_q;
	logic [HALF_W-1:0] low16;
	logic [BYTE_W-1:0] b;

	assign take  = valid_s1 && (!emit || !out_valid_q || !out_stall);
	assign b     = word_s1.code_byte;
	assign low16 = {b, low_q};

	always_comb begin
		phase_n   = phase_q;
		upper_n   = upper_q;
		held_op_n = held_op_q;
		low_n     = low_q;
		offset_n  = offset_q;
		start_n   = start_q;
		emit      = 1'b0;
		res       = '0;
		if (word_s1.end_of_code) begin
			emit             = 1'b1;
			res.opcode_out   = STOP_OPCODE;
			res.truncated    = (phase_q != PH_OPCODE);
			res.instr_offset = (phase_q != PH_OPCODE) ? start_q : offset_q;
			phase_n          = PH_OPCODE;
			upper_n          = '0;
			offset_n         = '0;
		end else begin
			offset_n = offset_q + HALF_W'(1);
			unique case (phase_q)
				PH_OPCODE, PH_EXT_OP: begin
					if (phase_q == PH_OPCODE)
						start_n = offset_q;
					if (phase_q == PH_OPCODE && b == cfg.extended_opcode) begin
						phase_n = PH_EXT_LO;
					end else begin
						held_op_n = b;
						if (b >= cfg.have_argument_threshold) begin
							phase_n = PH_ARG_LO;
						end else begin
							emit             = 1'b1;
							res.opcode_out   = b;
							res.instr_offset = start_n;
							phase_n          = PH_OPCODE;
							upper_n          = '0;
						end
					end
				end
				PH_EXT_LO: begin
					upper_n = {{(HALF_W-BYTE_W){1'b0}}, b};
					phase_n = PH_EXT_HI;
				end
				PH_EXT_HI: begin
					upper_n = {b, upper_q[BYTE_W-1:0]};
					phase_n = PH_EXT_OP;
				end
				PH_ARG_LO: begin
					low_n   = b;
					phase_n = PH_ARG_HI;
				end
				PH_ARG_HI: begin
					emit             = 1'b1;
					res.opcode_out   = held_op_q;
					res.has_argument = 1'b1;
					res.instr_offset = start_q;
					if (upper_q == '0)
						res.argument = {{(ARG_W-HALF_W){low16[HALF_W-1]}}, low16};
					else
						res.argument = {upper_q, low16};
					phase_n          = PH_OPCODE;
					upper_n          = '0;
				end
				default: begin
					phase_n = PH_OPCODE;
					upper_n = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_OPCODE;
			upper_q  <= '0;
			offset_q <= '0;
			start_q  <= '0;
		end else if (take) begin
			phase_q  <= phase_n;
			upper_q  <= upper_n;
			offset_q <= offset_n;
			start_q  <= start_n;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			held_op_q <= held_op_n;
			low_q     <= low_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit)
			out_word_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

// ===== rtl/core/bytecode_instruction_decoder.sv =====
// ----------------------------------------------------------------------------
// bytecode_instruction_decoder
// Assembles instructions from a stream of code bytes.
// ----------------------------------------------------------------------------
// Byte channel (byte_valid/byte_stall/byte_word): one code byte or an end
// marker per word. Instruction channel (instr_valid/instr_stall/instr_word):
// one word per completed instruction or end marker.
// A byte word is registered in the input register on acceptance and parsed in
// the next cycle; the result word that it completes passes through the result
// register to instr_valid. One byte word per cycle is sustained while
// instr_stall is low; the parse state machine and its result register set that figure.
// While instr_stall holds a result, byte words that complete no instruction are
// still parsed and taken; byte_stall rises only once the word in the input
// register would need the occupied result register.
// Reset clears the parse state, the offset counter and both channels' valid
// flags, and restores the threshold (90) and prefix opcode (145). The config
// port writes a register on any cycle with cfg_we high.
// ----------------------------------------------------------------------------
module bytecode_instruction_decoder import bid_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  in_word_t             byte_word,
	output logic                 instr_valid,
	input  logic                 instr_stall,
	output out_word_t            instr_word,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_t     cfg;
	logic     valid_s1;
	in_word_t word_s1;
	logic     take;

	bid_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign byte_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid)
			word_s1 <= byte_word;
	end

	bid_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_s1  (valid_s1),
		.word_s1   (word_s1),
		.take      (take),
		.out_valid (instr_valid),
		.out_stall (instr_stall),
		.out_word  (instr_word)
	);

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> valid_s1)
		else $error("byte_stall with empty input register");

	a_end_gives_stop: assert property (@(posedge clk) disable iff (!arst_n)
		take && word_s1.end_of_code |=>
			instr_valid && instr_word.opcode_out == STOP_OPCODE &&
			!instr_word.has_argument)
		else $error("end marker did not produce a stop word");

	a_no_arg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		instr_valid && !instr_word.has_argument |-> instr_word.argument == '0)
		else $error("argument set on word without argument");

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the bytecode instruction decoder against a cycle-free model of its
// parse state machine. Code bytes, end markers and broken instructions go in
// through a bursty sender. Results come out to a receiver that stalls on
// changing patterns and once holds off long enough to back the input up.
// Both registers are rewritten between phases, also mid-instruction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
	import bid_pkg::*;

	localparam int IDLE_LIMIT = 1000;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 byte_valid = 1'b0;
	logic                 byte_stall;
	in_word_t             byte_word = '0;
	logic                 instr_valid;
	logic                 instr_stall = 1'b0;
	out_word_t            instr_word;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_THRESHOLD;
	logic [CFG_W-1:0]     cfg_data = '0;

	bytecode_instruction_decoder u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_word   (byte_word),
		.instr_valid (instr_valid),
		.instr_stall (instr_stall),
		.instr_word  (instr_word),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #5 clk = ~clk;

	// decoder model state
	logic [CFG_W-1:0]  thr_cfg = THRESHOLD_RESET;
	logic [CFG_W-1:0]  ext_cfg = EXT_OPCODE_RESET;
	phase_t            parse_phase = PH_OPCODE;
	logic [HALF_W-1:0] ext_upper = '0;
	logic [BYTE_W-1:0] held_op = '0;
	logic [BYTE_W-1:0] arg_lo = '0;
	logic [HALF_W-1:0] byte_count = '0;
	logic [HALF_W-1:0] instr_start = '0;

	in_word_t  byte_queue[$];
	out_word_t instr_expect[$];
	out_word_t want;
	int        words_added = 0;
	int        errors = 0;
	logic      byte_taken = 1'b0;
	int        burst_left = 1;
	int        gap_left = 0;
	int        hold_left = 0;
	bit        long_hold_done = 1'b0;
	stall_mode_t stall_mode = STALL_NONE;
	int        mode_left = 0;
	int        idle_cycles = 0;

	function void decode_byte(input in_word_t w);
		out_word_t    r;
		logic [15:0]  low16;
		r = '0;
		if (w.end_of_code) begin
			r.opcode_out = STOP_OPCODE;
			r.truncated = (parse_phase != PH_OPCODE);
			r.instr_offset = r.truncated ? instr_start : byte_count;
			instr_expect.push_back(r);
			parse_phase = PH_OPCODE;
			ext_upper = '0;
			byte_count = '0;
			return;
		end
		case (parse_phase)
		PH_OPCODE, PH_EXT_OP: begin
			if (parse_phase == PH_OPCODE)
				instr_start = byte_count;
			if (parse_phase == PH_OPCODE && w.code_byte == ext_cfg) begin
				parse_phase = PH_EXT_LO;
			end else begin
				held_op = w.code_byte;
				if (w.code_byte >= thr_cfg) begin
					parse_phase = PH_ARG_LO;
				end else begin
					r.opcode_out = w.code_byte;
					r.instr_offset = instr_start;
					instr_expect.push_back(r);
					parse_phase = PH_OPCODE;
					ext_upper = '0;
				end
			end
		end
		PH_EXT_LO: begin
			ext_upper = {8'h00, w.code_byte};
			parse_phase = PH_EXT_HI;
		end
		PH_EXT_HI: begin
			ext_upper[15:8] = w.code_byte;
			parse_phase = PH_EXT_OP;
		end
		PH_ARG_LO: begin
			arg_lo = w.code_byte;
			parse_phase = PH_ARG_HI;
		end
		default: begin
			low16 = {w.code_byte, arg_lo};
			// zero extension word means plain sign extension
			if (ext_upper == '0)
				r.argument = {{16{low16[15]}}, low16};
			else
				r.argument = {ext_upper, low16};
			r.opcode_out = held_op;
			r.has_argument = 1'b1;
			r.instr_offset = instr_start;
			instr_expect.push_back(r);
			parse_phase = PH_OPCODE;
			ext_upper = '0;
		end
		endcase
		byte_count = byte_count + 16'd1;
	endfunction

	function void check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
			errors++;
		end
	endfunction

	task automatic push_word(input logic [7:0] b, input logic e);
		in_word_t w;
		w.code_byte = b;
		w.end_of_code = e;
		byte_queue.push_back(w);
		words_added++;
	endtask

	function automatic logic [15:0] arg_half();
		case ($urandom_range(0, 7))
		0: return 16'h0000;
		1: return 16'h7FFF;
		2: return 16'h8000;
		3: return 16'hFFFF;
		default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_arg_op(input logic [7:0] op);
		logic [15:0] v;
		push_word(op, 1'b0);
		if (op >= thr_cfg) begin
			v = arg_half();
			push_word(v[7:0], 1'b0);
			push_word(v[15:8], 1'b0);
		end
	endtask

	task automatic add_instr(input bit allow_end);
		int          kind;
		int          n;
		logic [7:0]  op;
		logic [15:0] hi;
		kind = allow_end ? $urandom_range(0, 99) : $urandom_range(23, 99);
		if (kind < 10) begin
			push_word(8'($urandom), $urandom_range(0, 5) == 0);
		end else if (kind < 18) begin
			push_word(8'($urandom), 1'b1);
		end else if (kind < 23) begin
			// stream ends partway through an instruction
			op = $urandom_range(0, 1) ? ext_cfg : 8'($urandom_range(thr_cfg, 255));
			push_word(op, 1'b0);
			n = $urandom_range(0, op == ext_cfg ? 2 : 1);
			repeat (n) push_word(8'($urandom), 1'b0);
			push_word(8'($urandom), 1'b1);
		end else if (kind < 48) begin
			op = (thr_cfg == 0) ? 8'($urandom) : 8'($urandom_range(0, thr_cfg - 1));
			push_arg_op(op);
		end else if (kind < 78) begin
			push_arg_op(8'($urandom_range(thr_cfg, 255)));
		end else begin
			hi = arg_half();
			push_word(ext_cfg, 1'b0);
			push_word(hi[7:0], 1'b0);
			push_word(hi[15:8], 1'b0);
			case ($urandom_range(0, 9))
			0: op = ext_cfg;
			1, 2: op = (thr_cfg == 0) ? 8'($urandom) : 8'($urandom_range(0, thr_cfg - 1));
			default: op = 8'($urandom_range(thr_cfg, 255));
			endcase
			push_arg_op(op);
		end
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_THRESHOLD)
			thr_cfg = val;
		else
			ext_cfg = val;
	endtask

	// the last byte of a partial instruction yields nothing, so allow it to settle
	task automatic drain();
		while (byte_queue.size() != 0 || byte_valid || instr_expect.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// byte sender
	always @(negedge clk) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
		end else if (!byte_valid || byte_taken) begin
			if (gap_left > 0) begin
				byte_valid <= 1'b0;
				gap_left--;
			end else if (byte_queue.size() == 0) begin
				byte_valid <= 1'b0;
			end else begin
				byte_valid <= 1'b1;
				byte_word <= byte_queue.pop_front();
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					case ($urandom_range(0, 9))
					0, 1, 2: gap_left = 0;
					9: gap_left = $urandom_range(10, 20);
					default: gap_left = $urandom_range(1, 4);
					endcase
				end else begin
					burst_left--;
				end
			end
		end
	end

	// instruction receiver stall
	always @(negedge clk) begin
		if (hold_left > 0) begin
			instr_stall <= 1'b1;
			hold_left--;
		end else begin
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			case (stall_mode)
			STALL_NONE:   instr_stall <= 1'b0;
			STALL_LIGHT:  instr_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY:  instr_stall <= ($urandom_range(0, 3) != 0);
			default:      instr_stall <= ~instr_stall;
			endcase
			if (arst_n && !long_hold_done && byte_queue.size() > 40) begin
				hold_left = 100;
				long_hold_done = 1'b1;
			end else if ($urandom_range(0, 2999) == 0) begin
				hold_left = $urandom_range(40, 100);
			end
		end
	end

	// result check and model update
	always @(posedge clk) begin
		if (arst_n) begin
			if (instr_valid && !instr_stall) begin
				if (instr_expect.size() == 0) begin
					$display("%0t: unexpected instruction word, expected none, got %p",
						$time, instr_word);
					errors++;
				end else begin
					want = instr_expect.pop_front();
					check_field("opcode_out", want.opcode_out, instr_word.opcode_out);
					check_field("argument", want.argument, instr_word.argument);
					check_field("has_argument", want.has_argument, instr_word.has_argument);
					check_field("instr_offset", want.instr_offset, instr_word.instr_offset);
					check_field("truncated", want.truncated, instr_word.truncated);
				end
			end
			if (byte_valid && !byte_stall)
				decode_byte(byte_word);
		end
		byte_taken <= arst_n && byte_valid && !byte_stall;
	end

	always @(posedge clk) begin
		if (!arst_n || (byte_valid && !byte_stall) || (instr_valid && !instr_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("bytecode_instruction_decoder test failed");
			$finish;
		end
	end

	initial begin
		logic [7:0] t;
		logic [7:0] e;
		int         start;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: threshold 90, prefix 145
		push_word(8'h00, 1'b0);
		push_word(8'd89, 1'b0);
		push_word(8'hFF, 1'b0);
		push_word(8'hFF, 1'b0);
		push_word(8'h7F, 1'b0);
		// zero extension word, sign extended
		push_word(8'd145, 1'b0);
		push_word(8'h00, 1'b0);
		push_word(8'h00, 1'b0);
		push_word(8'd90, 1'b0);
		push_word(8'h00, 1'b0);
		push_word(8'h80, 1'b0);
		// prefix after prefix
		push_word(8'd145, 1'b0);
		push_word(8'hFF, 1'b0);
		push_word(8'hFF, 1'b0);
		push_word(8'd145, 1'b0);
		push_word(8'hFF, 1'b0);
		push_word(8'hFF, 1'b0);
		// prefix then plain opcode
		push_word(8'd145, 1'b0);
		push_word(8'h34, 1'b0);
		push_word(8'h12, 1'b0);
		push_word(8'd10, 1'b0);
		// truncated inside a prefix, then a clean end
		push_word(8'd145, 1'b0);
		push_word(8'h12, 1'b0);
		push_word(8'hFF, 1'b1);
		push_word(8'h00, 1'b1);
		drain();

		for (int p = 0; p < 6; p++) begin
			case (p)
			0: begin t = THRESHOLD_RESET; e = EXT_OPCODE_RESET; end
			1: begin t = 8'd0; e = 8'd255; end
			2: begin t = 8'd255; e = 8'd0; end
			3: begin t = 8'd1; e = 8'($urandom); end
			4: begin t = 8'($urandom); e = 8'($urandom); end
			default: begin t = THRESHOLD_RESET; e = EXT_OPCODE_RESET; end
			endcase
			write_cfg(CFG_THRESHOLD, t);
			write_cfg(CFG_EXT_OPCODE, e);
			start = words_added;
			while (words_added - start < 75)
				add_instr(1'b1);
			// leave an instruction open across the register writes
			if ($urandom_range(0, 1)) begin
				push_word(8'($urandom_range(thr_cfg, 255)), 1'b0);
				if ($urandom_range(0, 1))
					push_word(8'($urandom), 1'b0);
			end else begin
				push_word(ext_cfg, 1'b0);
				repeat ($urandom_range(0, 2)) push_word(8'($urandom), 1'b0);
			end
			drain();
		end

		if (errors == 0)
			$display("bytecode_instruction_decoder test passed");
		else
			$display("bytecode_instruction_decoder test failed");
		$finish;
	end

endmodule
